// File: hdl/lns_pkg.sv
// Shared types and constants for the LIFO non-preemptive scheduler.
// Holds the channel item types, the job table entry and the control/status
// structs between controller and datapath. No dependencies.
`default_nettype none

package lns_pkg;

  localparam int ID_W   = 16;
  localparam int TIME_W = 16;
  localparam int SVC_W  = 16;
  localparam int TICK_W = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] arrival;
    logic [SVC_W-1:0]  service;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  run_id;
    logic [SVC_W-1:0] ticks_left;
    logic             busy_res;
    logic             all_done;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [SVC_W-1:0]  service;
  } job_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_ins;
    logic ins_shift;
    logic ins_wr;
    logic rd_push;
    logic push;
    logic rd_stk;
    logic rd_pop;
    logic load_run;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_op;
    logic full;
    logic ptr_gt_due;
    logic ins_greater;
    logic due_pending;
    logic arr_due;
    logic pop_needed;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/lns_if.sv
// Valid/ready channel interfaces for the scheduler's input and result items.
// Depends on lns_pkg for the item types.
`default_nettype none

interface lns_in_if;
  logic              valid;
  logic              ready;
  lns_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lns_out_if;
  logic               valid;
  logic               ready;
  lns_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/lifo_nonpreemptive_scheduler_core.sv
// LIFO non-preemptive job scheduler.
// The input channel carries items with op = load (job id, arrival tick,
// service length) or op = tick. A load inserts the job into an arrival-ordered
// table and produces no result; loads into a full table are dropped. A tick
// pushes every due job onto a ready stack, pops the newest job if none is
// running (zero-service jobs are discarded), and returns one result item with
// the running job's id and its remaining ticks, or zeros when idle, plus an
// all-done flag.
// A load walks down from the end of the table, moving each later arrival up
// one slot until it meets a job that does not arrive later or reaches
// next_due, then writes the new job; a load into a full table is dropped. A
// tick pushes due jobs in arrival order until one is not yet due, then pops
// the stack until a job is running or the stack is empty, then writes the
// result register. Reads of the job table give registered read data.
// One item is processed at a time; in_ready is high only between items. The
// result sits in an output register, so a new item is accepted while a result
// waits; a tick whose result register is still full waits at the end until
// the receiver takes the old result.
// Reset (synchronous, active low) empties the table and stack, clears the tick
// counter and the running job, and drops any pending result.
`default_nettype none

module lifo_nonpreemptive_scheduler_core #(
  parameter int MAX_JOBS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  lns_in_if.sink     in_ch,
  lns_out_if.source  out_ch
);

  lns_pkg::ctrl_cmd_t cmd;
  lns_pkg::dp_stat_t  stat;
  logic               in_ready;

  lns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lns_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch.payload),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.payload),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

// File: hdl/lns_ctrl.sv
// Controller state machine of the scheduler: sequences job insertion and the
// push, pop and report phases of a tick. Depends on lns_pkg.
`default_nettype none

module lns_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lns_pkg::dp_stat_t   stat,
  output lns_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_INS_CHK  = 10'b00_0000_0010,
    S_INS_CMP  = 10'b00_0000_0100,
    S_INS_WR   = 10'b00_0000_1000,
    S_PUSH_CHK = 10'b00_0001_0000,
    S_PUSH_CMP = 10'b00_0010_0000,
    S_POP_CHK  = 10'b00_0100_0000,
    S_POP_IDX  = 10'b00_1000_0000,
    S_POP_LD   = 10'b01_0000_0000,
    S_EMIT     = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.in_op == lns_pkg::OP_TICK) begin
            state_nxt = S_PUSH_CHK;
          end else if (!stat.full) begin
            state_nxt = S_INS_CHK;
          end
        end
      end
      // Walk down from the end of the table, moving later arrivals up one slot.
      S_INS_CHK: begin
        if (stat.ptr_gt_due) begin
          cmd.rd_ins = 1'b1;
          state_nxt  = S_INS_CMP;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_CMP: begin
        if (stat.ins_greater) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_CHK;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_PUSH_CHK: begin
        if (stat.due_pending) begin
          cmd.rd_push = 1'b1;
          state_nxt   = S_PUSH_CMP;
        end else begin
          state_nxt = S_POP_CHK;
        end
      end
      S_PUSH_CMP: begin
        if (stat.arr_due) begin
          cmd.push  = 1'b1;
          state_nxt = S_PUSH_CHK;
        end else begin
          state_nxt = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        if (stat.pop_needed) begin
          cmd.rd_stk = 1'b1;
          state_nxt  = S_POP_IDX;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_POP_IDX: begin
        cmd.rd_pop = 1'b1;
        state_nxt  = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.load_run = 1'b1;
        state_nxt    = S_POP_CHK;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lns_dp.sv
// Datapath of the scheduler: job table and ready stack memories, counters,
// the running job and the result register. Depends on lns_pkg.
`default_nettype none

module lns_dp #(
  parameter int MAX_JOBS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lns_pkg::in_item_t   in_item,
  input  wire                 out_ready,
  output logic                out_valid,
  output lns_pkg::out_item_t  out_item,
  input  lns_pkg::ctrl_cmd_t  cmd,
  output lns_pkg::dp_stat_t   stat
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // Job table, kept in arrival order from next_due upward.
  lns_pkg::job_t tbl [MAX_JOBS];
  lns_pkg::job_t tbl_rd_r;
  logic [IDX_W-1:0] tbl_ra;
  logic             tbl_re;
  logic [IDX_W-1:0] tbl_wa;
  logic             tbl_we;
  lns_pkg::job_t    tbl_wd;

  // Ready stack of table indices.
  logic [IDX_W-1:0] stk [MAX_JOBS];
  logic [IDX_W-1:0] stk_rd_r;

  lns_pkg::job_t    new_r;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] job_count_r, job_count_nxt;
  logic [CNT_W-1:0] next_due_r, next_due_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [lns_pkg::ID_W-1:0]   running_id_r, running_id_nxt;
  logic [lns_pkg::SVC_W-1:0]  running_left_r, running_left_nxt;
  logic [lns_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic               out_valid_r, out_valid_nxt;
  lns_pkg::out_item_t out_item_r;

  logic [CNT_W-1:0]          ptr_m1;
  logic [CNT_W-1:0]          depth_m1;
  logic                      busy;
  logic [lns_pkg::SVC_W-1:0] left_after;

  assign ptr_m1     = ptr_r - CNT_W'(1);
  assign depth_m1   = depth_r - CNT_W'(1);
  assign busy       = (running_left_r != '0);
  assign left_after = busy ? running_left_r - lns_pkg::SVC_W'(1) : '0;

  assign stat.in_op       = in_item.op;
  assign stat.full        = (job_count_r == CNT_W'(MAX_JOBS));
  assign stat.ptr_gt_due  = (ptr_r > next_due_r);
  assign stat.ins_greater = (tbl_rd_r.arrival > new_r.arrival);
  assign stat.due_pending = (next_due_r < job_count_r);
  assign stat.arr_due     = ({16'b0, tbl_rd_r.arrival} <= tick_r);
  assign stat.pop_needed  = !busy && (depth_r != '0);
  assign stat.out_free    = !out_valid_r || out_ready;

  // Table port selection.
  always_comb begin
    tbl_re = cmd.rd_ins | cmd.rd_push | cmd.rd_pop;
    tbl_ra = stk_rd_r;
    if (cmd.rd_ins) begin
      tbl_ra = ptr_m1[IDX_W-1:0];
    end else if (cmd.rd_push) begin
      tbl_ra = next_due_r[IDX_W-1:0];
    end
    tbl_we = cmd.ins_shift | cmd.ins_wr;
    tbl_wa = ptr_r[IDX_W-1:0];
    tbl_wd = cmd.ins_shift ? tbl_rd_r : new_r;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rd_r <= tbl[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk[depth_r[IDX_W-1:0]] <= next_due_r[IDX_W-1:0];
    end
    if (cmd.rd_stk) begin
      stk_rd_r <= stk[depth_m1[IDX_W-1:0]];
    end
  end

  always_comb begin
    ptr_nxt          = ptr_r;
    job_count_nxt    = job_count_r;
    next_due_nxt     = next_due_r;
    depth_nxt        = depth_r;
    running_id_nxt   = running_id_r;
    running_left_nxt = running_left_r;
    tick_nxt         = tick_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (cmd.capture) begin
      ptr_nxt = job_count_r;
    end
    if (cmd.ins_shift) begin
      ptr_nxt = ptr_m1;
    end
    if (cmd.ins_wr) begin
      job_count_nxt = job_count_r + CNT_W'(1);
    end
    if (cmd.push) begin
      depth_nxt    = depth_r + CNT_W'(1);
      next_due_nxt = next_due_r + CNT_W'(1);
    end
    if (cmd.rd_stk) begin
      depth_nxt = depth_m1;
    end
    // Jobs with zero service are dropped without taking a tick.
    if (cmd.load_run && (tbl_rd_r.service != '0)) begin
      running_id_nxt   = tbl_rd_r.id;
      running_left_nxt = tbl_rd_r.service;
    end
    if (cmd.emit) begin
      running_left_nxt = left_after;
      tick_nxt         = tick_r + lns_pkg::TICK_W'(1);
      out_valid_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r    <= '0;
      next_due_r     <= '0;
      depth_r        <= '0;
      running_id_r   <= '0;
      running_left_r <= '0;
      tick_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      job_count_r    <= job_count_nxt;
      next_due_r     <= next_due_nxt;
      depth_r        <= depth_nxt;
      running_id_r   <= running_id_nxt;
      running_left_r <= running_left_nxt;
      tick_r         <= tick_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.capture) begin
      new_r.id      <= in_item.job_id;
      new_r.arrival <= in_item.arrival;
      new_r.service <= in_item.service;
    end
    if (cmd.emit) begin
      out_item_r.run_id     <= busy ? running_id_r : '0;
      out_item_r.ticks_left <= running_left_r;
      out_item_r.busy_res   <= busy;
      out_item_r.all_done   <= (next_due_r >= job_count_r) && (depth_r == '0) &&
                               (left_after == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: hdl/lns_checker.sv
// Port-level checks for the scheduler core, attached by bind.
// Depends on lns_pkg and the top level's channel interfaces.
`default_nettype none

module lns_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input lns_pkg::in_item_t   in_item,
  input wire                 out_valid,
  input wire                 out_ready,
  input lns_pkg::out_item_t  out_item
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // A load never produces a result on its own.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_item.op == lns_pkg::OP_LOAD) |=> !$rose(out_valid))
    else $error("result appeared after a load item");

  // The block is busy right after taking a tick.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_item.op == lns_pkg::OP_TICK) |=> !in_ready)
    else $error("next item taken while a tick was in progress");

  // An idle result carries zero id and count.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.busy_res |-> (out_item.run_id == '0) &&
                                        (out_item.ticks_left == '0))
    else $error("idle result with nonzero fields");

  // A running job reports all done only when it reports its last tick left.
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.busy_res && out_item.all_done |-> out_item.ticks_left == 16'd1)
    else $error("all done reported while a job still has ticks left");

endmodule

bind lifo_nonpreemptive_scheduler_core lns_checker u_lns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_item   (in_ch.payload),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for lifo_nonpreemptive_scheduler_core.
// Drives load and tick items through the lns_in_if channel, predicts every
// tick report from its own job table and ready stack, and checks the results.
// Depends on lns_pkg, lns_if.sv and the scheduler core RTL.
module tb;

  localparam int MAX_JOBS    = 16;
  localparam int IDX_W       = $clog2(MAX_JOBS);
  localparam int RAND_TICKS  = 1200;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 120;

  // Idling per phase: none, sender idle, receiver stalling, both.
  localparam int SEND_IDLE_PCT[4]  = '{0, 57, 0, 20};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 57, 20};

  logic clk = 1'b0;
  logic rst_n;

  lns_in_if  job_in ();
  lns_out_if report_out ();

  lifo_nonpreemptive_scheduler_core #(
    .MAX_JOBS(MAX_JOBS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (job_in),
    .out_ch(report_out)
  );

  always #1 clk = ~clk;

  // Predicted scheduler state.
  lns_pkg::job_t             job_tbl[MAX_JOBS];
  logic [IDX_W-1:0]          ready_stk[MAX_JOBS];
  int                        job_cnt;
  int                        next_due;
  int                        stk_depth;
  logic [lns_pkg::ID_W-1:0]  run_id;
  logic [lns_pkg::SVC_W-1:0] run_left;
  logic [lns_pkg::TICK_W-1:0] cur_tick;

  lns_pkg::out_item_t tick_report_q[$];
  lns_pkg::in_item_t  job_stim_q[$];

  int   total_items;
  int   items_accepted;
  int   loads_applied;
  int   ticks_applied;
  int   reports_checked;
  int   busy_reports;
  int   err_cnt;
  int   idle_cycles;
  logic in_taken;

  // Stimulus generation bookkeeping.
  int gen_tick;
  int jobs_queued;

  task automatic sched_step(input lns_pkg::in_item_t it);
    int                 pos;
    logic [IDX_W-1:0]   idx;
    lns_pkg::out_item_t rpt;
    if (it.op == lns_pkg::OP_LOAD) begin
      loads_applied++;
      if (job_cnt < MAX_JOBS) begin
        // Jobs already pushed keep their slots; insertion starts at next_due.
        pos = next_due;
        while (pos < job_cnt && job_tbl[pos].arrival <= it.arrival) pos++;
        for (int k = job_cnt; k > pos; k--) job_tbl[k] = job_tbl[k-1];
        job_tbl[pos].id      = it.job_id;
        job_tbl[pos].arrival = it.arrival;
        job_tbl[pos].service = it.service;
        job_cnt++;
      end
    end else begin
      ticks_applied++;
      while (next_due < job_cnt &&
             lns_pkg::TICK_W'(job_tbl[next_due].arrival) <= cur_tick &&
             stk_depth < MAX_JOBS) begin
        ready_stk[stk_depth] = IDX_W'(next_due);
        stk_depth++;
        next_due++;
      end
      while (run_left == '0 && stk_depth > 0) begin
        stk_depth--;
        idx = ready_stk[stk_depth];
        if (job_tbl[idx].service != '0) begin
          run_id   = job_tbl[idx].id;
          run_left = job_tbl[idx].service;
        end
      end
      rpt = '0;
      if (run_left != '0) begin
        rpt.run_id     = run_id;
        rpt.ticks_left = run_left;
        rpt.busy_res   = 1'b1;
        run_left       = run_left - 1'b1;
      end
      cur_tick = cur_tick + 1'b1;
      rpt.all_done = (next_due >= job_cnt) && (stk_depth == 0) && (run_left == '0);
      tick_report_q.push_back(rpt);
    end
  endtask

  task automatic queue_load(input logic [lns_pkg::ID_W-1:0] id,
                            input logic [lns_pkg::TIME_W-1:0] arr,
                            input logic [lns_pkg::SVC_W-1:0] svc);
    lns_pkg::in_item_t it;
    it.op      = lns_pkg::OP_LOAD;
    it.job_id  = id;
    it.arrival = arr;
    it.service = svc;
    job_stim_q.push_back(it);
    jobs_queued++;
  endtask

  // Tick items carry random payload bits, which the block ignores.
  task automatic queue_ticks(input int n);
    lns_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.op      = lns_pkg::OP_TICK;
      it.job_id  = lns_pkg::ID_W'($urandom);
      it.arrival = lns_pkg::TIME_W'($urandom);
      it.service = lns_pkg::SVC_W'($urandom);
      job_stim_q.push_back(it);
      gen_tick++;
    end
  endtask

  function automatic int cur_phase();
    if (total_items == 0) return 0;
    return (items_accepted * 4) / total_items;
  endfunction

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      job_in.valid     <= 1'b0;
      report_out.ready <= 1'b0;
    end else begin
      if (!job_in.valid || in_taken) begin
        if (job_stim_q.size() != 0 &&
            $urandom_range(0, 99) >= SEND_IDLE_PCT[cur_phase() % 4]) begin
          job_in.payload <= job_stim_q.pop_front();
          job_in.valid   <= 1'b1;
        end else begin
          job_in.valid <= 1'b0;
        end
      end
      report_out.ready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[cur_phase() % 4]);
    end
  end

  // Monitor: results are checked before the new item is predicted, since a
  // result leaving at this edge always belongs to an earlier tick.
  always @(posedge clk) begin
    lns_pkg::out_item_t want;
    lns_pkg::out_item_t got;
    in_taken <= rst_n && job_in.valid && job_in.ready;
    if (rst_n) begin
      if (report_out.valid && report_out.ready) begin
        got = report_out.payload;
        if (tick_report_q.size() == 0) begin
          $display("%0t unexpected tick report: got id=%h left=%h busy=%b done=%b",
                   $time, got.run_id, got.ticks_left, got.busy_res, got.all_done);
          err_cnt++;
        end else begin
          want = tick_report_q.pop_front();
          reports_checked++;
          if (got.busy_res === 1'b1) busy_reports++;
          if (got.run_id !== want.run_id || got.ticks_left !== want.ticks_left ||
              got.busy_res !== want.busy_res || got.all_done !== want.all_done) begin
            $display("%0t tick report mismatch: expected id=%h left=%h busy=%b done=%b,",
                     $time, want.run_id, want.ticks_left, want.busy_res, want.all_done);
            $display("%0t   got id=%h left=%h busy=%b done=%b",
                     $time, got.run_id, got.ticks_left, got.busy_res, got.all_done);
            err_cnt++;
          end
        end
      end
      if (job_in.valid && job_in.ready) begin
        sched_step(job_in.payload);
        items_accepted++;
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((job_in.valid && job_in.ready) || (report_out.valid && report_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int base;
    int arr;
    int svc;
    rst_n            = 1'b0;
    job_in.valid     = 1'b0;
    job_in.payload   = '0;
    report_out.ready = 1'b0;
    in_taken         = 1'b0;
    job_cnt          = 0;
    next_due         = 0;
    stk_depth        = 0;
    run_id           = '0;
    run_left         = '0;
    cur_tick         = '0;
    items_accepted   = 0;
    loads_applied    = 0;
    ticks_applied    = 0;
    reports_checked  = 0;
    busy_reports     = 0;
    err_cnt          = 0;
    idle_cycles      = 0;
    total_items      = 0;
    gen_tick         = 0;
    jobs_queued      = 0;

    // Directed: an idle tick with an empty table, extreme ids, a zero-service
    // job, equal arrivals, and a late job whose arrival has already passed.
    queue_ticks(1);
    queue_load(16'hFFFF, 16'd0, 16'd1);
    queue_load(16'h0000, 16'd0, 16'd0);
    queue_load(16'h1234, 16'd2, 16'd3);
    queue_load(16'h0007, 16'd0, 16'd2);
    queue_ticks(2);
    queue_load(16'hAAAA, 16'd1, 16'd5);
    queue_ticks(13);

    // Random: bursts of jobs due soon, some already late, then the rest of
    // the table filled with jobs that never come due, then loads into a
    // full table mixed in as noise.
    for (int i = 0; i < RAND_TICKS; i++) begin
      if (i % 240 == 40 && jobs_queued < MAX_JOBS - 1) begin
        n = $urandom_range(2, 5);
        if (n > MAX_JOBS - 1 - jobs_queued) n = MAX_JOBS - 1 - jobs_queued;
        base = gen_tick + $urandom_range(0, 10);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 3) == 0)
            arr = gen_tick - $urandom_range(0, 3);
          else
            arr = base + $urandom_range(0, 8);
          if (arr < 0) arr = 0;
          svc = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 14);
          queue_load(lns_pkg::ID_W'($urandom), lns_pkg::TIME_W'(arr),
                     lns_pkg::SVC_W'(svc));
          if ($urandom_range(0, 2) == 0) queue_ticks(1);
        end
      end
      if (i == 1000) begin
        while (jobs_queued < MAX_JOBS)
          queue_load(lns_pkg::ID_W'($urandom),
                     16'h8000 | lns_pkg::TIME_W'($urandom_range(0, 16'h7FFF)),
                     16'hFFFF);
      end
      if (jobs_queued >= MAX_JOBS && $urandom_range(0, 9) == 0)
        queue_load(lns_pkg::ID_W'($urandom), lns_pkg::TIME_W'($urandom),
                   lns_pkg::SVC_W'($urandom));
      queue_ticks(1);
    end
    total_items = job_stim_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_accepted != total_items || tick_report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d loads and %0d ticks over four idling phases;",
             loads_applied, ticks_applied);
    $display("%0d tick reports checked, %0d of them with a job running.",
             reports_checked, busy_reports);
    if (err_cnt == 0 && tick_report_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lns_pkg.sv
hdl/lns_if.sv
hdl/lns_ctrl.sv
hdl/lns_dp.sv
hdl/lifo_nonpreemptive_scheduler_core.sv
hdl/lns_checker.sv
tb/sv/tb.sv
